// File: hdl/maf_pkg.sv
// Shared constants and control types for the moving average filter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package maf_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int SAMPLE_W    = 16;
  localparam int WIN_W       = 7;
  localparam int FILL_W      = 7;
  localparam int AVG_W       = 24;
  localparam int FRAC_BITS   = 8;
  localparam int SUM_W       = SAMPLE_W + PTR_W + 1;
  localparam int DVD_W       = SUM_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DVD_W + 1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // capture the sample word and read the oldest slot
    logic update;     // store the sample, adjust the sum and the count
    logic div_start;  // start the mean division
    logic out_load;   // load the output register
  } maf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } maf_status_t;

endpackage

// File: hdl/maf_div.sv
// Restoring divider, one quotient bit per cycle, for the filter mean.
// Depends on maf_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module maf_div import maf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        quo   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        // The remainder stays below the divisor, so it fits the count width.
        quo   <= {quo[DVD_W-2:0], fits};
        rem   <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/maf_datapath.sv
// Datapath of the moving average filter: sample ring, count, running sum,
// divider and output register. Depends on maf_pkg and maf_div.
`timescale 1ns / 1ps

module maf_datapath import maf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [WIN_W-1:0]           cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  maf_cmd_t                   cmd,
  output maf_status_t                status,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [AVG_W-1:0]    average,
  output logic [FILL_W-1:0]          fill_count
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  logic signed [SAMPLE_W-1:0] store [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] oldest_q;
  logic [WIN_W-1:0]           window_size;
  logic [PTR_W-1:0]           write_pointer;
  logic [CNT_W-1:0]           stored_count;
  logic signed [SUM_W-1:0]    running_sum;
  logic                       drop;
  logic                       neg;

  logic [CNT_W-1:0]           win_eff;
  logic [CNT_W:0]             ptr_ext;
  logic [CNT_W:0]             cnt_ext;
  logic [CNT_W:0]             oldest_full;
  logic [PTR_W-1:0]           rd_addr;
  logic signed [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]           sum_mag;
  logic [DVD_W-1:0]           dividend;
  logic                       div_done;
  logic [DVD_W-1:0]           quotient;
  logic [AVG_W-1:0]           quo_low;

  // A zero window acts as one, and a window beyond the ring acts as the ring.
  always_comb begin
    if (window_size == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_size) > STORE_DEPTH) begin
      win_eff = DEPTH_CNT;
    end else begin
      win_eff = CNT_W'(window_size);
    end
  end

  // The oldest sample lies stored_count slots behind the write pointer.
  assign ptr_ext = (CNT_W+1)'(write_pointer);
  assign cnt_ext = (CNT_W+1)'(stored_count);
  assign oldest_full = (ptr_ext >= cnt_ext) ? ptr_ext - cnt_ext
                                            : ptr_ext + (CNT_W+1)'(STORE_DEPTH) - cnt_ext;
  assign rd_addr = oldest_full[PTR_W-1:0];

  assign sum_next = running_sum - (drop ? SUM_W'(oldest_q) : SUM_W'(0)) + SUM_W'(sample_q);

  assign sum_mag  = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign dividend = {sum_mag, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_q <= sample;
      oldest_q <= store[rd_addr];
    end
    if (cmd.update) begin
      store[write_pointer] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      stored_count  <= '0;
      running_sum   <= '0;
      drop          <= 1'b0;
      neg           <= 1'b0;
    end else begin
      if (cmd.take) begin
        drop <= (stored_count >= win_eff) && (stored_count != '0);
      end
      if (cmd.update) begin
        running_sum   <= sum_next;
        stored_count  <= stored_count - CNT_W'(drop) + CNT_W'(1);
        write_pointer <= (write_pointer == PTR_W'(STORE_DEPTH - 1)) ? '0
                                                                   : write_pointer + PTR_W'(1);
      end
      if (cmd.div_start) begin
        neg <= running_sum[SUM_W-1];
      end
    end
  end

  maf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (stored_count),
    .done     (div_done),
    .quotient (quotient)
  );

  assign quo_low = quotient[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average    <= neg ? AVG_W'(-quo_low) : quo_low;
      fill_count <= FILL_W'(stored_count);
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !result_valid || !result_stall;

endmodule

// File: hdl/maf_ctrl.sv
// Controller of the moving average filter: sequences one sample word
// through read, update, division and output. Depends on maf_pkg.
`timescale 1ns / 1ps

module maf_ctrl import maf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  maf_status_t status,
  output maf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_WAIT,
    S_DELIVER
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= S_START;
        S_START:  state <= S_WAIT;
        S_WAIT: begin
          if (status.div_done) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_stall  = (state != S_IDLE);
  assign cmd.take      = (state == S_IDLE) && sample_valid;
  assign cmd.update    = (state == S_UPDATE);
  assign cmd.div_start = (state == S_START);
  assign cmd.out_load  = (state == S_DELIVER) && status.out_free;

endmodule

// File: hdl/moving_average_filter.sv
// Top level of the moving average filter: joins controller and datapath.
// Depends on maf_pkg, maf_ctrl and maf_datapath.
//
//   channel   valid          stall          payload
//   input     sample_valid   sample_stall   sample
//   output    result_valid   result_stall   average, fill_count
//   config    cfg_we         -              cfg_wdata (window_size)
//
// A sample word accepted at one edge is stored and added to the sum, then the
// bit-serial divider forms the mean, and the result goes to the output register.
// The next word is accepted in the cycle after the result is loaded, so the
// block takes no new word while one is in flight. Reset clears the pointer,
// count, sum and window (to 8). A stalled result holds; the next result waits
// in the controller until the output register frees.
`timescale 1ns / 1ps

module moving_average_filter import maf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [WIN_W-1:0]           cfg_wdata,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [AVG_W-1:0]    average,
  output logic [FILL_W-1:0]          fill_count
);

  maf_cmd_t    cmd;
  maf_status_t status;

  maf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  maf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .fill_count   (fill_count)
  );

endmodule

// File: dv/maf_checker.sv
// Scoreboard for the moving average filter: watches the config port and both
// channels, predicts each result word and compares it field by field.
// Depends on maf_pkg for widths and the reset window.
`timescale 1ns / 1ps

module maf_checker import maf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [WIN_W-1:0]           cfg_wdata,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic signed [AVG_W-1:0]    average,
  input  logic [FILL_W-1:0]          fill_count,
  output int                         pending,
  output int                         fails
);

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [FILL_W-1:0]       fill;
  } mean_word_t;

  mean_word_t                 mean_queue[$];
  logic signed [SAMPLE_W-1:0] history[STORE_DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  int                         held_count;
  int                         window_sum;
  logic [WIN_W-1:0]           window_q;

  task automatic report_mismatch(input string msg);
    if (fails < 50) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    fails++;
  endtask

  task automatic predict_mean(input logic signed [SAMPLE_W-1:0] s);
    int               win;
    longint           scaled;
    mean_word_t       e;
    logic [PTR_W-1:0] oldest;
    win = window_q;
    if (win == 0) win = 1;
    if (win > STORE_DEPTH) win = STORE_DEPTH;
    // Only one word leaves per item, so a shrunk window never lowers the count.
    if (held_count >= win && held_count > 0) begin
      oldest = wr_ptr - PTR_W'(held_count);
      window_sum -= history[oldest];
      held_count--;
    end
    history[wr_ptr] = s;
    wr_ptr++;
    held_count++;
    window_sum += s;
    // Signed division truncates toward zero, as the mean requires.
    scaled    = longint'(window_sum) * 256;
    e.average = AVG_W'(scaled / longint'(held_count));
    e.fill    = FILL_W'(held_count);
    mean_queue.insert(mean_queue.size(), e);
  endtask

  task automatic check_mean();
    mean_word_t e;
    if (mean_queue.size() == 0) begin
      report_mismatch($sformatf("result word with nothing pending: average %0d fill %0d",
                                $signed(average), fill_count));
    end else begin
      e = mean_queue[0];
      mean_queue.delete(0);
      if (average !== e.average)
        report_mismatch($sformatf("average got %0d expected %0d",
                                  $signed(average), $signed(e.average)));
      if (fill_count !== e.fill)
        report_mismatch($sformatf("fill_count got %0d expected %0d", fill_count, e.fill));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mean_queue.delete();
      wr_ptr     = '0;
      held_count = 0;
      window_sum = 0;
      window_q   = WIN_RESET;
    end else begin
      if (cfg_we) window_q = cfg_wdata;
      if (sample_valid && !sample_stall) predict_mean(sample);
      if (result_valid && !result_stall) check_mean();
    end
    pending = mean_queue.size();
  end

endmodule

// File: dv/moving_average_filter_tb.sv
// Testbench top for the moving average filter: clock, reset, stimulus with
// random idling on both channels, and the verdict. Depends on maf_pkg,
// maf_checker and the moving_average_filter block.
`timescale 1ns / 1ps

module moving_average_filter_tb import maf_pkg::*; ();

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_WORDS  = 77;
  localparam int RANDOM_PHASES = 10;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [WIN_W-1:0]           cfg_wdata    = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample       = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [AVG_W-1:0]    average;
  logic [FILL_W-1:0]          fill_count;

  int pending;
  int fails;
  int cycle_count  = 0;
  int stall_left   = 0;
  int stall_draw;
  bit send_quiet   = 1'b0;
  bit result_quiet = 1'b0;

  moving_average_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .fill_count   (fill_count)
  );

  maf_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average),
    .fill_count   (fill_count),
    .pending      (pending),
    .fails        (fails)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The stall count only runs down while a result word is offered.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && !result_stall) begin
      stall_draw = result_quiet ? 0 : $urandom_range(0, 5);
      stall_left   <= stall_draw;
      result_stall <= (stall_draw != 0);
    end else if (result_valid && stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
      3:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Valid stays high across back-to-back words; it drops only for a gap or a drain.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int                        n_words;
    int                        win;
    logic signed [SAMPLE_W-1:0] s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A zero window acts as one.
    write_window(WIN_W'(0));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    write_window(WIN_W'(1));
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    write_window(WIN_W'(2));
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    write_window(WIN_W'(5));
    repeat (3) send_sample(16'sh7FFF);
    send_sample(-16'sd3);
    send_sample(16'shFFFF);
    // Shrinking the window keeps the fill count where it was.
    write_window(WIN_W'(2));
    send_sample(16'sd100);
    send_sample(-16'sd7);
    // A window above the store depth acts as the full depth.
    write_window(WIN_W'(127));
    repeat (5) send_sample(16'sh7FFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       win = $urandom_range(1, 12);
        1:       win = $urandom_range(1, 16);
        2:       win = $urandom_range(1, 24);
        3:       win = $urandom_range(1, 32);
        4:       win = $urandom_range(1, 48);
        5:       win = STORE_DEPTH;
        6:       win = 127;
        7:       win = 0;
        8:       win = $urandom_range(0, 127);
        default: win = 1;
      endcase
      write_window(WIN_W'(win));
      send_quiet   = ($urandom_range(0, 3) == 0);
      result_quiet = ($urandom_range(0, 3) == 0);
      n_words = (p == 5) ? 2 * STORE_DEPTH + 10 : PHASE_WORDS;
      for (int i = 0; i < n_words; i++) begin
        // The full-depth phase drives the sum to both of its extremes.
        if (p == 5 && i < 2 * STORE_DEPTH)
          s = (i < STORE_DEPTH) ? 16'sh7FFF : 16'sh8000;
        else
          s = draw_sample();
        send_sample(s);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
